@@ hw/rtl/ccrp_pkg.sv @@
// Shared types and constants of the coil current ramp profile block.
// Field widths, register map, configuration and work-queue structures.
// No dependencies; every other file of the block imports this package.
package ccrp_pkg;

    // Field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned AMPS_W    = 16;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned FACTOR_W  = 18;

    // Highest coil count honored when picking the last coil
    localparam int unsigned MAX_COILS = 64;

    // Datapath widths of the scaling divider
    localparam int unsigned SHAPE_W   = 32;                 // shape numerator
    localparam int unsigned DIV_W     = 31;                 // 19200 * den
    localparam int unsigned PROD_W    = AMPS_W + SHAPE_W;   // amps * shape
    localparam int unsigned NUM_W     = DIV_W + FACTOR_W;   // rounded numerator

    // Full-scale current 300 A in 1/64 A units times the Q16 level one, over 65536
    localparam logic [14:0] SCALE_DIV = 15'd19200;

    // Q0.16 level of one
    localparam logic [TICK_W:0] LEVEL_ONE = 17'h10000;

    // Work queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Stream data widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 24;

    // Register port
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_LSB    = 2;
    localparam int unsigned REG_IDX_W  = ADDR_W - REG_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_STEP  = 3'd0,
        REG_FALL_STEP   = 3'd1,
        REG_SHORT_RAMP  = 3'd2,
        REG_OVERLAP     = 3'd3,
        REG_FULL_RAMP   = 3'd4,
        REG_COIL_COUNT  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0]  first_step_level;
        logic [TICK_W-1:0]  fall_step_level;
        logic [TICK_W-1:0]  short_ramp_ticks;
        logic [TICK_W-1:0]  overlap_ticks;
        logic [TICK_W-1:0]  full_ramp_ticks;
        logic [COUNT_W-1:0] coil_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        first_step_level: 16'd32768,
        fall_step_level:  16'd32768,
        short_ramp_ticks: 16'd100,
        overlap_ticks:    16'd100,
        full_ramp_ticks:  16'd100,
        coil_count:       7'd12
    };

    // One classified request: shape = lead_prod + trail_prod over den
    typedef struct packed {
        logic [SHAPE_W-1:0] lead_prod;
        logic [SHAPE_W-1:0] trail_prod;
        logic [TICK_W-1:0]  den;
        logic [AMPS_W-1:0]  amps;
    } work_t;

endpackage

@@ hw/rtl/coil_current_ramp_profile_top.sv @@
// Top level of the coil current ramp profile block.
// Instantiates ccrp_regs, ccrp_front, ccrp_queue and ccrp_back; depends on ccrp_pkg.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one request per beat:
//   coil index, sample time, switch-on time, switch-off time and coil current.
//   Output stream (m_tvalid/m_tready/m_tdata) returns one field factor per
//   request, in request order, as unsigned Q2.16 saturated at all ones.
//   The APB-style port sets ramp levels, durations and the coil count; write it
//   only while no request is in flight.
//   An accepted request passes two front stages, one queue slot, three back
//   stages (shape sum, multiply, rounding), a saturation check and 18
//   restoring-divide stages, one quotient bit each, before m_tvalid.
//   Throughput is one request per cycle unless m_tready stalls the output.
//   A stalled m_tready holds the back pipeline; the front keeps accepting
//   until the four-entry work queue fills, then drops s_tready.
//   Reset clears all valid bits and the queue and loads the register defaults.
module coil_current_ramp_profile_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ccrp_pkg::ADDR_W-1:0]         paddr,
    input  logic [ccrp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ccrp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coil_index[5:0], sample_time[37:6], switch_on_time[69:38],
    // switch_off_time[101:70], coil_amps[117:102], zero[119:118]
    input  logic [ccrp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // field_factor[17:0], zero[23:18]
    output logic [ccrp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import ccrp_pkg::*;

    cfg_t                cfg;
    logic [IDX_W-1:0]    coil_index;
    logic [TIME_W-1:0]   sample_time;
    logic [TIME_W-1:0]   switch_on_time;
    logic [TIME_W-1:0]   switch_off_time;
    logic [AMPS_W-1:0]   coil_amps;
    logic                push;
    logic                pop;
    logic                queue_full;
    logic                queue_empty;
    work_t               push_data;
    work_t               head_data;
    logic [FACTOR_W-1:0] field_factor;

    // Unpack the request
    assign coil_index      = s_tdata[5:0];
    assign sample_time     = s_tdata[37:6];
    assign switch_on_time  = s_tdata[69:38];
    assign switch_off_time = s_tdata[101:70];
    assign coil_amps       = s_tdata[117:102];

    assign m_tdata = OUT_TDATA_W'(field_factor);

    ccrp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccrp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .coil_index      (coil_index),
        .sample_time     (sample_time),
        .switch_on_time  (switch_on_time),
        .switch_off_time (switch_off_time),
        .coil_amps       (coil_amps),
        .queue_full      (queue_full),
        .push            (push),
        .push_data       (push_data)
    );

    ccrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_data (head_data)
    );

    ccrp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!queue_empty),
        .head_data    (head_data),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .field_factor (field_factor)
    );

endmodule

@@ hw/rtl/ccrp_regs.sv @@
// Configuration registers of the coil current ramp profile block.
// APB-style write and read port; depends on ccrp_pkg.
module ccrp_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccrp_pkg::ADDR_W-1:0]       paddr,
    input  logic [ccrp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ccrp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ccrp_pkg::cfg_t                    cfg
);
    import ccrp_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Decode the write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FIRST_STEP: cfg_next.first_step_level = pwdata[TICK_W-1:0];
                REG_FALL_STEP:  cfg_next.fall_step_level  = pwdata[TICK_W-1:0];
                REG_SHORT_RAMP: cfg_next.short_ramp_ticks = pwdata[TICK_W-1:0];
                REG_OVERLAP:    cfg_next.overlap_ticks    = pwdata[TICK_W-1:0];
                REG_FULL_RAMP:  cfg_next.full_ramp_ticks  = pwdata[TICK_W-1:0];
                REG_COIL_COUNT: cfg_next.coil_count       = pwdata[COUNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_FIRST_STEP: prdata = APB_DATA_W'(cfg_reg.first_step_level);
            REG_FALL_STEP:  prdata = APB_DATA_W'(cfg_reg.fall_step_level);
            REG_SHORT_RAMP: prdata = APB_DATA_W'(cfg_reg.short_ramp_ticks);
            REG_OVERLAP:    prdata = APB_DATA_W'(cfg_reg.overlap_ticks);
            REG_FULL_RAMP:  prdata = APB_DATA_W'(cfg_reg.full_ramp_ticks);
            REG_COIL_COUNT: prdata = APB_DATA_W'(cfg_reg.coil_count);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/ccrp_front.sv @@
// Front end: accepts requests, picks the profile segment and forms the shape products.
// Two registered stages feeding the work queue; depends on ccrp_pkg.
module ccrp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ccrp_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ccrp_pkg::IDX_W-1:0]       coil_index,
    input  logic [ccrp_pkg::TIME_W-1:0]      sample_time,
    input  logic [ccrp_pkg::TIME_W-1:0]      switch_on_time,
    input  logic [ccrp_pkg::TIME_W-1:0]      switch_off_time,
    input  logic [ccrp_pkg::AMPS_W-1:0]      coil_amps,
    input  logic                             queue_full,
    output logic                             push,
    output ccrp_pkg::work_t                  push_data
);
    import ccrp_pkg::*;

    // Segment decode signals
    logic [TIME_W:0]    t_x;
    logic [TIME_W:0]    on_x;
    logic [TIME_W:0]    off_x;
    logic [TIME_W:0]    d_x;
    logic [TIME_W:0]    rc_x;
    logic [TIME_W:0]    r1_x;
    logic [TIME_W:0]    r1_ov_x;
    logic [TIME_W:0]    off_rc_x;
    logic [TIME_W:0]    off_r1_x;
    logic [TIME_W:0]    t_ov_x;
    logic [TICK_W-1:0]  d_lo;
    logic [TICK_W-1:0]  t_lo;
    logic [TICK_W-1:0]  off_lo;
    logic [COUNT_W-1:0] cnt_clamped;
    logic               is_off;
    logic               is_first;
    logic               is_last;

    logic [TICK_W:0]    lead_mul_next;
    logic [TICK_W-1:0]  lead_op_next;
    logic [TICK_W:0]    trail_mul_next;
    logic [TICK_W-1:0]  trail_op_next;
    logic [TICK_W-1:0]  den_next;

    // Stage A
    logic               a_valid_reg;
    logic [TICK_W:0]    a_lead_mul_reg;
    logic [TICK_W-1:0]  a_lead_op_reg;
    logic [TICK_W:0]    a_trail_mul_reg;
    logic [TICK_W-1:0]  a_trail_op_reg;
    logic [TICK_W-1:0]  a_den_reg;
    logic [AMPS_W-1:0]  a_amps_reg;

    // Stage B
    logic               b_valid_reg;
    work_t              b_data_reg;
    logic [2*TICK_W:0]  lead_full;
    logic [2*TICK_W:0]  trail_full;

    logic               advance;

    // Move both stages together whenever stage B can hand off
    assign advance   = !b_valid_reg || !queue_full;
    assign in_ready  = advance;
    assign push      = b_valid_reg && !queue_full;
    assign push_data = b_data_reg;

    // Exact time sums, one bit wider than the inputs so nothing wraps
    assign t_x      = {1'b0, sample_time};
    assign on_x     = {1'b0, switch_on_time};
    assign off_x    = {1'b0, switch_off_time};
    assign d_x      = t_x - on_x;
    assign rc_x     = (TIME_W+1)'(cfg.full_ramp_ticks);
    assign r1_x     = (TIME_W+1)'(cfg.short_ramp_ticks);
    assign r1_ov_x  = r1_x + (TIME_W+1)'(cfg.overlap_ticks);
    assign off_rc_x = off_x + rc_x;
    assign off_r1_x = off_x + r1_x;
    assign t_ov_x   = t_x + (TIME_W+1)'(cfg.overlap_ticks);

    // Segment offsets fit in 16 bits where used, so low halves suffice
    assign d_lo   = d_x[TICK_W-1:0];
    assign t_lo   = sample_time[TICK_W-1:0];
    assign off_lo = switch_off_time[TICK_W-1:0];

    // Coil role
    assign cnt_clamped = (cfg.coil_count > COUNT_W'(MAX_COILS)) ?
                         COUNT_W'(MAX_COILS) : cfg.coil_count;
    assign is_off   = (t_x <= on_x) || (switch_on_time == switch_off_time);
    assign is_first = (coil_index == '0);
    assign is_last  = !is_first && (cnt_clamped != '0) &&
                      (COUNT_W'(coil_index) == cnt_clamped - 1'b1);

    // Pick the segment; first match wins
    always_comb
    begin
        lead_mul_next  = '0;
        lead_op_next   = '0;
        trail_mul_next = '0;
        trail_op_next  = '0;
        den_next       = TICK_W'(1);
        if (!is_off)
        begin
            if (is_first && d_x < rc_x)
            begin
                lead_mul_next = LEVEL_ONE;
                lead_op_next  = d_lo;
                den_next      = cfg.full_ramp_ticks;
            end
            else if (!is_first && d_x < r1_x)
            begin
                lead_mul_next = {1'b0, cfg.first_step_level};
                lead_op_next  = d_lo;
                den_next      = cfg.short_ramp_ticks;
            end
            else if (!is_first && d_x < r1_ov_x)
            begin
                lead_mul_next  = {1'b0, cfg.first_step_level};
                lead_op_next   = cfg.overlap_ticks;
                trail_mul_next = LEVEL_ONE - {1'b0, cfg.first_step_level};
                trail_op_next  = d_lo - cfg.short_ramp_ticks;
                den_next       = cfg.overlap_ticks;
            end
            else if (is_last)
            begin
                if (t_x < off_x)
                begin
                    lead_mul_next = LEVEL_ONE;
                    lead_op_next  = TICK_W'(1);
                end
                else if (t_x < off_rc_x)
                begin
                    lead_mul_next = LEVEL_ONE;
                    lead_op_next  = off_lo + cfg.full_ramp_ticks - t_lo;
                    den_next      = cfg.full_ramp_ticks;
                end
            end
            else if (t_ov_x < off_x)
            begin
                lead_mul_next = LEVEL_ONE;
                lead_op_next  = TICK_W'(1);
            end
            else if (t_x < off_x)
            begin
                lead_mul_next  = {1'b0, cfg.fall_step_level};
                lead_op_next   = cfg.overlap_ticks;
                trail_mul_next = LEVEL_ONE - {1'b0, cfg.fall_step_level};
                trail_op_next  = off_lo - t_lo;
                den_next       = cfg.overlap_ticks;
            end
            else if (t_x < off_r1_x)
            begin
                lead_mul_next = {1'b0, cfg.fall_step_level};
                lead_op_next  = off_lo + cfg.short_ramp_ticks - t_lo;
                den_next      = cfg.short_ramp_ticks;
            end
        end
    end

    // Shape products; each stays below 2^32
    assign lead_full  = (2*TICK_W+1)'(a_lead_mul_reg) * (2*TICK_W+1)'(a_lead_op_reg);
    assign trail_full = (2*TICK_W+1)'(a_trail_mul_reg) * (2*TICK_W+1)'(a_trail_op_reg);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_lead_mul_reg        <= lead_mul_next;
            a_lead_op_reg         <= lead_op_next;
            a_trail_mul_reg       <= trail_mul_next;
            a_trail_op_reg        <= trail_op_next;
            a_den_reg             <= den_next;
            a_amps_reg            <= coil_amps;
            b_data_reg.lead_prod  <= lead_full[SHAPE_W-1:0];
            b_data_reg.trail_prod <= trail_full[SHAPE_W-1:0];
            b_data_reg.den        <= a_den_reg;
            b_data_reg.amps       <= a_amps_reg;
        end
    end

endmodule

@@ hw/rtl/ccrp_queue.sv @@
// Short work queue between the front end and the scaling back end.
// Register-based FIFO of ccrp_pkg::work_t entries; depends on ccrp_pkg.
module ccrp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ccrp_pkg::work_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output ccrp_pkg::work_t  head_data
);
    import ccrp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/ccrp_back.sv @@
// Back end: scales the shape by the coil current and divides, rounded and saturated.
// Sum, multiply and rounding stages, a saturation check and one restoring-divide
// stage per quotient bit, the last one being the output register; depends on ccrp_pkg.
module ccrp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  ccrp_pkg::work_t                head_data,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ccrp_pkg::FACTOR_W-1:0]  field_factor
);
    import ccrp_pkg::*;

    logic                advance;

    // Stage 1: shape sum and divisor
    logic [SHAPE_W:0]    shape_sum;
    logic [DIV_W-1:0]    div_next;
    logic                s1_valid_reg;
    logic [SHAPE_W-1:0]  s1_shape_reg;
    logic [DIV_W-1:0]    s1_div_reg;
    logic [AMPS_W-1:0]   s1_amps_reg;

    // Stage 2: current times shape
    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [DIV_W-1:0]    s2_div_reg;

    // Stage 3: add half the divisor for round-to-nearest
    logic [NUM_W-1:0]    num_next;
    logic                s3_valid_reg;
    logic [NUM_W-1:0]    s3_num_reg;
    logic [DIV_W-1:0]    s3_div_reg;

    // Divide stages: index 0 holds the saturation check
    logic [FACTOR_W-1:0] dv_valid_reg;
    logic [NUM_W-1:0]    rem_reg  [FACTOR_W];
    logic [DIV_W-1:0]    dvs_reg  [FACTOR_W];
    logic [FACTOR_W-1:0] quo_reg  [FACTOR_W];
    logic                sat_reg  [FACTOR_W];
    logic [NUM_W-1:0]    step_sub [1:FACTOR_W];
    logic                step_fit [1:FACTOR_W];
    logic [NUM_W-1:0]    rem_next [1:FACTOR_W];
    logic [FACTOR_W-1:0] quo_next [1:FACTOR_W];
    logic                sat_next;

    logic                out_valid_reg;
    logic [FACTOR_W-1:0] out_data_reg;

    // Whole pipeline moves unless the output is held
    assign advance      = !out_valid_reg || out_ready;
    assign pop          = advance && head_valid;
    assign out_valid    = out_valid_reg;
    assign field_factor = out_data_reg;

    assign shape_sum = (SHAPE_W+1)'(head_data.lead_prod) +
                       (SHAPE_W+1)'(head_data.trail_prod);
    assign div_next  = DIV_W'(head_data.den) * DIV_W'(SCALE_DIV);
    assign num_next  = NUM_W'(s2_prod_reg) + NUM_W'(s2_div_reg >> 1);
    assign sat_next  = (s3_num_reg >= {s3_div_reg, {FACTOR_W{1'b0}}});

    // One quotient bit per stage, most significant first
    always_comb
    begin
        for (int k = 1; k <= FACTOR_W; k++)
        begin
            step_sub[k] = NUM_W'(dvs_reg[k-1]) << (FACTOR_W - k);
            step_fit[k] = (rem_reg[k-1] >= step_sub[k]);
            rem_next[k] = step_fit[k] ? rem_reg[k-1] - step_sub[k] : rem_reg[k-1];
            quo_next[k] = {quo_reg[k-1][FACTOR_W-2:0], step_fit[k]};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[FACTOR_W-2:0], s3_valid_reg};
            out_valid_reg <= dv_valid_reg[FACTOR_W-1];
        end
    end

    // Payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_shape_reg <= shape_sum[SHAPE_W-1:0];
            s1_div_reg   <= div_next;
            s1_amps_reg  <= head_data.amps;
            s2_prod_reg  <= PROD_W'(s1_amps_reg) * PROD_W'(s1_shape_reg);
            s2_div_reg   <= s1_div_reg;
            s3_num_reg   <= num_next;
            s3_div_reg   <= s2_div_reg;
            rem_reg[0]   <= s3_num_reg;
            dvs_reg[0]   <= s3_div_reg;
            quo_reg[0]   <= '0;
            sat_reg[0]   <= sat_next;
            for (int k = 1; k < FACTOR_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                quo_reg[k] <= quo_next[k];
                sat_reg[k] <= sat_reg[k-1];
            end
            out_data_reg <= sat_reg[FACTOR_W-1] ? {FACTOR_W{1'b1}} : quo_next[FACTOR_W];
        end
    end

endmodule

@@ hw/rtl/ccrp_checker.sv @@
// Port-level checks for the coil current ramp profile block.
// Bound to coil_current_ramp_profile_top; depends on ccrp_pkg.
module ccrp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccrp_pkg::ADDR_W-1:0]       paddr,
    input  logic [ccrp_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [ccrp_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ccrp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import ccrp_pkg::*;

    // Hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed or dropped while stalled");

    // Keep the pad bits of a result at zero
    property p_out_pad;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:FACTOR_W] == '0;
    endproperty
    a_out_pad: assert property (p_out_pad)
        else $error("result pad bits not zero");

    // No result right out of reset
    property p_reset_empty;
        @(posedge clk)
        $rose(rst_n) |-> !m_tvalid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result valid right after reset");

    // Read back the level just written
    property p_cfg_readback;
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[ADDR_W-1:REG_LSB] == REG_FIRST_STEP) ##1
        (psel && !pwrite && paddr[ADDR_W-1:REG_LSB] == REG_FIRST_STEP)
        |-> prdata[TICK_W-1:0] == $past(pwdata[TICK_W-1:0]);
    endproperty
    a_cfg_readback: assert property (p_cfg_readback)
        else $error("register read does not return the written value");

endmodule

bind coil_current_ramp_profile_top ccrp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
